// ===== design/thermistor_steinhart_hart_temp_unit_defines.svh =====
`ifndef THERMISTOR_STEINHART_HART_TEMP_UNIT_DEFINES_SVH
`define THERMISTOR_STEINHART_HART_TEMP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define SHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sht check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define SHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sht check failed");

`endif

// ===== design/sht_pkg.sv =====
package sht_pkg;

  localparam int unsigned RAW_W     = 14;
  localparam int unsigned SER_W     = 24;
  localparam int unsigned DIFF_W    = 17;  // holds 2^14 for the widest (RAW_W-bit) converter
  localparam int unsigned LN_IN_W   = 40;  // series_ohms * (fs - raw), widest case
  localparam int unsigned EXP_W     = 6;
  localparam int unsigned FRAC_W    = 28;
  localparam int unsigned LN_W      = 30;  // ln in Q24, unsigned
  localparam int unsigned MAG_W     = 30;
  localparam int unsigned SQ_W      = 36;
  localparam int unsigned CUBE_W    = 42;
  localparam int unsigned TB_W      = 55;
  localparam int unsigned TERMS_W   = 56;
  localparam int unsigned SUM_W     = 58;  // signed sum
  localparam int unsigned DIV_W     = 56;  // positive sum and dividend
  localparam int unsigned Q_W       = 17;
  localparam int unsigned TEMP_W    = 18;

  localparam int unsigned LN_LAT    = FRAC_W + 2;
  localparam int unsigned DIV_LAT   = Q_W + 1;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [DIV_W-1:0] HUNDRED_Q48 = DIV_W'(100) << 48;
  localparam logic signed [TEMP_W:0] ABS_ZERO_CENTI = 19'sd27315;
  localparam logic signed [TEMP_W:0] TEMP_MAX       = 19'sd100000;

  localparam logic [47:0] COEF_A_RST = 48'd317826827700;
  localparam logic [47:0] COEF_B_RST = 48'd65900328422;
  localparam logic [39:0] COEF_C_RST = 40'd24678070;
  localparam logic [23:0] SERIES_RST = 24'd10000;

  typedef enum logic [1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_SERIES = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic zero;
    logic bad;
  } flags_t;

endpackage

// ===== design/thermistor_steinhart_hart_temp_unit.sv =====
// NTC thermistor to temperature, Steinhart-Hart, fixed point.
// Input channel: raw_count_i with in_valid_i / in_stall_o; the item is taken
// at a clock edge with valid high and stall low. Output channel: temp_centi_c_o
// (hundredths of a degree C), zero_input_o, out_of_range_o with out_valid_o /
// out_stall_i. Every input item gives exactly one result item.
// Throughput is one item per cycle while the output is not stalled; the depth
// comes from the 28 squaring steps of each log unit and the 17 restoring steps
// of the reciprocal divider.
// When the output holds a result and out_stall_i is high the whole pipeline
// freezes and in_stall_o rises in the same cycle; nothing is dropped.
// Coefficients and the series resistor sit on an APB port at byte address
// 8*index (coef_a, coef_b, coef_c, series_ohms); write them only while idle.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the
// default coefficients; no clearing pass is needed.
module thermistor_steinhart_hart_temp_unit import sht_pkg::*; #(
  parameter int unsigned ADC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [RAW_W-1:0]         raw_count_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TEMP_W-1:0] temp_centi_c_o,
  output logic                     zero_input_o,
  output logic                     out_of_range_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);

  localparam int unsigned TOT = 1 + LN_LAT + 6 + DIV_LAT + 1;
  localparam logic [DIFF_W-1:0] FS = DIFF_W'(1) << ADC_BITS;

  // configuration
  logic [47:0]      coef_a_q, coef_b_q;
  logic [39:0]      coef_c_q;
  logic [SER_W-1:0] series_q;
  cfg_reg_e         reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= COEF_A_RST;
      coef_b_q <= COEF_B_RST;
      coef_c_q <= COEF_C_RST;
      series_q <= SERIES_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_COEF_A: coef_a_q <= pwdata[47:0];
        REG_COEF_B: coef_b_q <= pwdata[47:0];
        REG_COEF_C: coef_c_q <= pwdata[39:0];
        REG_SERIES: series_q <= pwdata[SER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (reg_sel)
        REG_COEF_A: prdata = {16'd0, coef_a_q};
        REG_COEF_B: prdata = {16'd0, coef_b_q};
        REG_COEF_C: prdata = {24'd0, coef_c_q};
        REG_SERIES: prdata = {40'd0, series_q};
        default:    prdata = '0;
      endcase
    end
  end

  // pipeline control
  logic           en;
  logic [TOT-1:0] vld_q;

  assign in_stall_o  = vld_q[TOT-1] && out_stall_i;
  assign en          = !in_stall_o;
  assign out_valid_o = vld_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  // input stage: divider resistance numerator and special cases
  logic [DIFF_W-1:0]       diff;
  logic [SER_W+DIFF_W-1:0] x1_full;
  logic [LN_IN_W-1:0]      x1_q, x2_q;
  flags_t                  fl_q [0:TOT-2];

  assign diff    = FS - DIFF_W'(raw_count_i);
  assign x1_full = series_q * diff;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q       <= x1_full[LN_IN_W-1:0];
      x2_q       <= LN_IN_W'(raw_count_i);
      fl_q[0].zero <= raw_count_i == '0;
      fl_q[0].bad  <= (DIFF_W'(raw_count_i) >= FS) || (series_q == '0);
      for (int i = 1; i < int'(TOT - 1); i++) fl_q[i] <= fl_q[i-1];
    end
  end

  logic [LN_W-1:0] ln1, ln2;

  sht_ln u_ln_r (.clk_i(clk_i), .en_i(en), .x_i(x1_q), .ln_o(ln1));
  sht_ln u_ln_c (.clk_i(clk_i), .en_i(en), .x_i(x2_q), .ln_o(ln2));

  // ln(R) sign and magnitude
  logic signed [LN_W:0] lnr;
  logic [MAG_W-1:0]     mag_q, mag_a_q;
  logic                 neg_q, neg_a_q, neg_b_q, neg_c_q, neg_d_q;

  assign lnr = $signed({1'b0, ln1}) - $signed({1'b0, ln2});

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= lnr[LN_W];
      mag_q <= lnr[LN_W] ? MAG_W'(-lnr) : MAG_W'(lnr);
    end
  end

  // polynomial terms, products split where the coefficient is wide
  logic [2*MAG_W-1:0]      sq_full;
  logic [SQ_W-1:0]         sq_q;
  logic [24+MAG_W-1:0]     blo_q, bhi_q;
  logic [SQ_W+MAG_W-1:0]   cube_full;
  logic [CUBE_W-1:0]       cube_q;
  logic [TB_W-1:0]         tb_q, tb_c_q;
  logic [20+CUBE_W-1:0]    clo_q, chi_q;
  logic [20+CUBE_W+19:0]   tc_full;
  logic [TERMS_W-1:0]      terms_q;
  logic signed [SUM_W-1:0] s_sum;
  logic [DIV_W-1:0]        s_q;
  logic                    sok_q [0:DIV_LAT];

  assign sq_full   = mag_q * mag_q;
  assign cube_full = sq_q * mag_a_q;
  assign tc_full   = {chi_q, 20'd0} + {20'd0, clo_q};
  assign s_sum     = neg_d_q ? $signed({10'd0, coef_a_q}) - $signed({2'b0, terms_q})
                             : $signed({10'd0, coef_a_q}) + $signed({2'b0, terms_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q     <= sq_full[2*MAG_W-1:24];
      blo_q    <= coef_b_q[23:0] * mag_q;
      bhi_q    <= coef_b_q[47:24] * mag_q;
      mag_a_q  <= mag_q;
      neg_a_q  <= neg_q;

      cube_q   <= cube_full[SQ_W+MAG_W-1:24];
      tb_q     <= {1'b0, bhi_q} + TB_W'(blo_q[24+MAG_W-1:24]);
      neg_b_q  <= neg_a_q;

      clo_q    <= coef_c_q[19:0] * cube_q;
      chi_q    <= coef_c_q[39:20] * cube_q;
      tb_c_q   <= tb_q;
      neg_c_q  <= neg_b_q;

      terms_q  <= TERMS_W'(tc_full[20+CUBE_W+19:24]) + TERMS_W'(tb_c_q);
      neg_d_q  <= neg_c_q;

      s_q      <= s_sum[DIV_W-1:0];
      sok_q[0] <= !s_sum[SUM_W-1] && (s_sum != '0);
      for (int i = 1; i <= int'(DIV_LAT); i++) sok_q[i] <= sok_q[i-1];
    end
  end

  logic [Q_W-1:0] q;
  logic           ovf;

  sht_div u_div (.clk_i(clk_i), .en_i(en), .s_i(s_q), .q_o(q), .ovf_o(ovf));

  // final: kelvin to Celsius, zero-input result, saturation
  logic signed [TEMP_W:0] tmp;
  logic [TEMP_W-1:0]      temp_q;
  logic                   zero_q, oor_q;
  flags_t                 fl_end;

  assign fl_end = fl_q[TOT-2];
  assign tmp    = $signed({2'b0, q}) - ABS_ZERO_CENTI;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fl_end.zero) begin
        temp_q <= TEMP_W'(-ABS_ZERO_CENTI);
        zero_q <= 1'b1;
        oor_q  <= 1'b0;
      end else if (fl_end.bad || !sok_q[DIV_LAT] || ovf || (tmp > TEMP_MAX)) begin
        temp_q <= TEMP_W'(TEMP_MAX);
        zero_q <= 1'b0;
        oor_q  <= 1'b1;
      end else begin
        temp_q <= tmp[TEMP_W-1:0];
        zero_q <= 1'b0;
        oor_q  <= 1'b0;
      end
    end
  end

  assign temp_centi_c_o = $signed(temp_q);
  assign zero_input_o   = zero_q;
  assign out_of_range_o = oor_q;

endmodule

// ===== design/sht_ln.sv =====
module sht_ln import sht_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [LN_IN_W-1:0] x_i,
  output logic [LN_W-1:0]    ln_o
);

  logic [EXP_W-1:0]  e_q  [0:FRAC_W];
  logic [31:0]       m_q  [0:FRAC_W];
  logic [FRAC_W-1:0] fr_q [0:FRAC_W];
  logic [LN_W-1:0]   ln_q;

  logic [EXP_W-1:0]   top_idx;
  logic [LN_IN_W-1:0] aligned;

  // top set bit, then left-align so the mantissa is the top 32 bits
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < int'(LN_IN_W); i++) begin
      if (x_i[i]) top_idx = EXP_W'(i);
    end
    aligned = x_i << (EXP_W'(LN_IN_W - 1) - top_idx);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0]  <= top_idx;
      m_q[0]  <= aligned[LN_IN_W-1 -: 32];
      fr_q[0] <= '0;
    end
  end

  // one log2 fraction bit per stage by squaring
  for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
    logic [63:0] prod;
    logic [32:0] sq;
    assign prod = m_q[k-1] * m_q[k-1];
    assign sq   = prod[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[k]  <= e_q[k-1];
        m_q[k]  <= sq[32] ? sq[32:1] : sq[31:0];
        fr_q[k] <= fr_q[k-1] | (sq[32] ? (FRAC_W'(1) << (FRAC_W - k)) : '0);
      end
    end
  end

  logic [63:0] ln_prod;
  assign ln_prod = {e_q[FRAC_W], fr_q[FRAC_W]} * LN2_Q30 + (64'd1 << 33);

  always_ff @(posedge clk_i) begin
    if (en_i) ln_q <= ln_prod[63:34];
  end

  assign ln_o = ln_q;

endmodule

// ===== design/sht_div.sv =====
module sht_div import sht_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] s_i,
  output logic [Q_W-1:0]   q_o,
  output logic             ovf_o
);

  localparam int unsigned CMP_W = DIV_W + Q_W;

  logic [DIV_W-1:0] r_q   [0:Q_W];
  logic [DIV_W-1:0] s_q   [0:Q_W];
  logic [Q_W-1:0]   q_q   [0:Q_W];
  logic             ovf_q [0:Q_W];

  logic [DIV_W-1:0] num;
  assign num = HUNDRED_Q48 + (s_i >> 1);

  // quotient of 2^17 or more is already past the hot limit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num;
      s_q[0]   <= s_i;
      q_q[0]   <= '0;
      ovf_q[0] <= {{Q_W{1'b0}}, num} >= {s_i, {Q_W{1'b0}}};
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [CMP_W-1:0] sh;
    logic             ge;
    assign sh = {{Q_W{1'b0}}, s_q[k-1]} << (Q_W - k);
    assign ge = {{Q_W{1'b0}}, r_q[k-1]} >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? (r_q[k-1] - sh[DIV_W-1:0]) : r_q[k-1];
        s_q[k]   <= s_q[k-1];
        q_q[k]   <= q_q[k-1] | (ge ? (Q_W'(1) << (Q_W - k)) : '0);
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[Q_W];
  assign ovf_o = ovf_q[Q_W];

endmodule

// ===== design/sht_chk.sv =====
`include "thermistor_steinhart_hart_temp_unit_defines.svh"

module sht_chk import sht_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [TEMP_W-1:0] temp_centi_c_o,
  input logic                     zero_input_o,
  input logic                     out_of_range_o
);

  // input side only backs up when a result is waiting and being held
  `SHT_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  `SHT_ASSERT_NXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(temp_centi_c_o))

  `SHT_ASSERT_IMP(a_zero, out_valid_o && zero_input_o, temp_centi_c_o == -18'sd27315 && !out_of_range_o)

  `SHT_ASSERT_IMP(a_sat, out_valid_o && out_of_range_o, temp_centi_c_o == 18'sd100000 && !zero_input_o)

endmodule

bind thermistor_steinhart_hart_temp_unit sht_chk u_sht_chk (.*);
